FILE: rtl/iib_pkg.sv
// ----------------------------------------------------------------------------
// iib_pkg: shared types and constants of the inverted index builder
// Command codes, status codes, sizes and the configuration register map.
// ----------------------------------------------------------------------------
package iib_pkg;

  // Sizes; the port widths are fixed to these
  localparam int MAX_RECORDS = 1024;
  localparam int TOKEN_IDS   = 1024;
  localparam int MAX_ENTRIES = 4096;

  // Command codes
  localparam logic [1:0] CMD_PUSH   = 2'd0;
  localparam logic [1:0] CMD_FINISH = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_BUILT = 3'd1;
  localparam logic [2:0] ST_NO_TOKEN  = 3'd2;
  localparam logic [2:0] ST_RANGE     = 3'd3;
  localparam logic [2:0] ST_OVERFLOW  = 3'd4;

  // Register map
  localparam logic [0:0] REG_FREQ_LIMIT = 1'd0;
  localparam logic [12:0] FREQ_LIMIT_RESET = 13'd2;

  // One result transaction
  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  record_number;
    logic [12:0] list_length;
    logic [12:0] total_entries;
    logic [10:0] distinct_tokens;
  } result_t;

endpackage

FILE: rtl/iib_cfg.sv
// ----------------------------------------------------------------------------
// iib_cfg: configuration register file
// APB-style port holding the frequency limit register.
// ----------------------------------------------------------------------------
module iib_cfg
  import iib_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [12:0] frequency_limit
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[1:0] == 2'd0);

  // Write the limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      frequency_limit <= FREQ_LIMIT_RESET;
    end else if (wr_en && (paddr[2:2] == REG_FREQ_LIMIT)) begin
      frequency_limit <= pwdata[12:0];
    end
  end

  // Read back
  always_comb begin
    prdata = 32'd0;
    if (paddr[2:2] == REG_FREQ_LIMIT && paddr[1:0] == 2'd0) begin
      prdata = {19'd0, frequency_limit};
    end
  end

endmodule

FILE: rtl/iib_core.sv
// ----------------------------------------------------------------------------
// iib_core: sequencer and shared counter/adder unit
// Holds the token, count, offset and entry memories and walks them for
// push, finish, read and clear commands.
// ----------------------------------------------------------------------------
module iib_core
  import iib_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [1:0]  cmd,
  input  logic [9:0]  token_id,
  input  logic        end_of_record,
  input  logic [11:0] entry_position,
  input  logic [12:0] frequency_limit,
  output logic        busy,
  output logic        done,
  output result_t     result
);

  localparam int EW = $clog2(MAX_ENTRIES);
  localparam int TW = $clog2(TOKEN_IDS);
  localparam int RW = $clog2(MAX_RECORDS + 1);
  localparam int SW = $clog2(MAX_ENTRIES + 1);
  localparam int CW = 13;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLR   = 4'd1;  // zero counts and fills
  localparam logic [3:0] S_CNT_R = 4'd2;  // read token store
  localparam logic [3:0] S_CNT_A = 4'd3;  // take token
  localparam logic [3:0] S_CNT_W = 4'd4;  // increment count
  localparam logic [3:0] S_OFF_R = 4'd5;  // read count for prefix
  localparam logic [3:0] S_OFF_W = 4'd6;  // lay out start
  localparam logic [3:0] S_FIL_R = 4'd7;  // step to previous token
  localparam logic [3:0] S_FIL_A = 4'd8;  // read token and record
  localparam logic [3:0] S_FIL_W = 4'd9;  // place entry
  localparam logic [3:0] S_RD_A  = 4'd10;
  localparam logic [3:0] S_RD_B  = 4'd11;
  localparam logic [3:0] S_RD_C  = 4'd12;
  localparam logic [3:0] S_DONE  = 4'd13;
  localparam logic [3:0] S_CNT_B = 4'd14; // read count
  localparam logic [3:0] S_FIL_T = 4'd15; // take token

  // Memories
  logic [9:0]  token_store     [MAX_ENTRIES];
  logic [9:0]  record_of_token [MAX_ENTRIES];
  logic [9:0]  entry_memory    [MAX_ENTRIES];
  logic [CW-1:0] token_counts  [TOKEN_IDS];
  logic [CW-1:0] list_start    [TOKEN_IDS];
  logic [CW-1:0] list_fill     [TOKEN_IDS];

  logic [3:0]    state;
  logic [SW-1:0] stored_tokens;
  logic [RW-1:0] current_record;
  logic          built_flag;
  logic          overflow_flag;
  logic [SW:0]   idx;          // walk index
  logic [TW-1:0] tok;          // current token
  logic [CW-1:0] cnt_q, start_q, fill_q;
  logic [9:0]    ts_q, rt_q, em_q;
  logic [CW-1:0] offset;
  logic [10:0]   nz;
  logic [11:0]   pos;
  logic [1:0]    op;
  logic          keep;

  function automatic logic tok_ok_push();
    tok_ok_push = (32'(token_id) < TOKEN_IDS) &&
                  (32'(stored_tokens) < MAX_ENTRIES) &&
                  (32'(current_record) < MAX_RECORDS);
  endfunction

  function automatic result_t status_only(logic [2:0] code);
    result_t r;
    r = '0;
    r.status = code;
    return r;
  endfunction

  assign busy = (state != S_IDLE);
  assign keep = (cnt_q >= frequency_limit);

  // Memory reads, registered
  always_ff @(posedge clk) begin
    ts_q    <= token_store[idx[EW-1:0]];
    rt_q    <= record_of_token[idx[EW-1:0]];
    cnt_q   <= token_counts[tok];
    start_q <= list_start[tok];
    fill_q  <= list_fill[tok];
    em_q    <= entry_memory[EW'(start_q + CW'(pos))];
  end

  // Memory writes
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start && cmd == CMD_PUSH && tok_ok_push()) begin
      token_store[stored_tokens[EW-1:0]]     <= token_id;
      record_of_token[stored_tokens[EW-1:0]] <= 10'(current_record);
    end
    if (state == S_CLR) begin
      token_counts[tok] <= '0;
      list_fill[tok]    <= '0;
    end
    if (state == S_CNT_W) token_counts[tok] <= cnt_q + 1'b1;
    if (state == S_OFF_W && keep) list_start[tok] <= offset;
    if (state == S_FIL_W && keep) begin
      entry_memory[EW'(start_q + fill_q)] <= rt_q;
      list_fill[tok] <= fill_q + 1'b1;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR; stored_tokens <= '0; current_record <= '0;
      built_flag <= 1'b0; overflow_flag <= 1'b0; done <= 1'b0;
      tok <= '0; op <= CMD_CLEAR; idx <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: if (start) begin
          op <= cmd; pos <= entry_position;
          case (cmd)
            CMD_PUSH: begin
              if (tok_ok_push()) begin
                stored_tokens <= stored_tokens + 1'b1;
                if (end_of_record) current_record <= current_record + 1'b1;
                built_flag <= 1'b0;
                result <= status_only(overflow_flag ? ST_OVERFLOW : ST_OK);
              end else begin
                overflow_flag <= 1'b1;
                result <= status_only(ST_OVERFLOW);
              end
              done <= 1'b1;
            end
            CMD_FINISH: begin
              result <= '0; tok <= '0; state <= S_CLR;
            end
            CMD_READ: begin
              if (!built_flag) begin
                result <= status_only(ST_NOT_BUILT); done <= 1'b1;
              end else if (32'(token_id) >= TOKEN_IDS) begin
                result <= status_only(ST_NO_TOKEN); done <= 1'b1;
              end else begin
                result <= '0; tok <= TW'(token_id); state <= S_RD_A;
              end
            end
            default: begin
              result <= '0;
              stored_tokens <= '0; current_record <= '0;
              built_flag <= 1'b0; overflow_flag <= 1'b0;
              tok <= '0; state <= S_CLR;
            end
          endcase
        end
        S_CLR: begin
          tok <= tok + 1'b1;
          if (32'(tok) == TOKEN_IDS - 1) begin
            tok <= '0; idx <= '0;
            state <= (op == CMD_FINISH) ? S_CNT_R : S_IDLE;
          end
        end
        S_CNT_R: begin
          if (idx == (SW+1)'(stored_tokens)) begin
            tok <= '0; offset <= '0; nz <= '0; state <= S_OFF_R;
          end else state <= S_CNT_A;
        end
        S_CNT_A: begin tok <= TW'(ts_q); state <= S_CNT_B; end
        S_CNT_B: state <= S_CNT_W;  // wait for count read
        S_CNT_W: begin idx <= idx + 1'b1; state <= S_CNT_R; end
        S_OFF_R: state <= S_OFF_W;
        S_OFF_W: begin
          if (cnt_q != '0) nz <= nz + 1'b1;
          if (keep) offset <= offset + cnt_q;
          tok <= tok + 1'b1;
          if (32'(tok) == TOKEN_IDS - 1) begin
            idx <= (SW+1)'(stored_tokens); state <= S_FIL_R;
          end else state <= S_OFF_R;
        end
        S_FIL_R: begin
          if (idx == '0) begin
            built_flag <= 1'b1;
            result.status <= overflow_flag ? ST_OVERFLOW : ST_OK;
            result.total_entries <= offset;
            result.distinct_tokens <= nz;
            done <= 1'b1; state <= S_IDLE;
          end else begin
            idx <= idx - 1'b1; state <= S_FIL_A;
          end
        end
        S_FIL_A: state <= S_FIL_T;  // wait for token and record read
        S_FIL_T: begin tok <= TW'(ts_q); state <= S_DONE; end
        S_DONE: state <= S_FIL_W;  // wait for table reads
        S_FIL_W: state <= S_FIL_R;
        S_RD_A: state <= S_RD_B;   // count, start, fill read
        S_RD_B: begin
          if (!keep) begin
            result.status <= ST_NO_TOKEN; done <= 1'b1; state <= S_IDLE;
          end else if (13'(pos) >= fill_q) begin
            result.status <= ST_RANGE; result.list_length <= fill_q;
            done <= 1'b1; state <= S_IDLE;
          end else state <= S_RD_C;
        end
        // Entry memory read, registered out of S_RD_B, is ready here
        S_RD_C: begin
          result.status <= ST_OK; result.list_length <= fill_q;
          result.record_number <= em_q; done <= 1'b1; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/inverted_index_builder_top.sv
// ----------------------------------------------------------------------------
// inverted_index_builder_top: inverted index builder
// A push, or a read before the index is built, returns its result in the
// cycle after acceptance and busy stays low, so such commands can follow
// back to back. A read that looks up the tables holds busy until its result,
// whether the token is not indexed, the position is out of range or an
// entry is returned. Finish holds busy through the single-port walks: a
// clearing sweep of the count tables, a count step per stored token, a
// layout step per token id to lay out the lists and a fill step per stored
// token. Clear and reset sweep the count tables over every token id. The
// result strobe done is high for one cycle and the receiver cannot stall it.
// ----------------------------------------------------------------------------
module inverted_index_builder_top
  import iib_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  output logic        done,
  input  logic [1:0]  cmd,
  input  logic [9:0]  token_id,
  input  logic        end_of_record,
  input  logic [11:0] entry_position,
  output logic [2:0]  status,
  output logic [9:0]  record_number,
  output logic [12:0] list_length,
  output logic [12:0] total_entries,
  output logic [10:0] distinct_tokens,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [12:0] frequency_limit;
  result_t     result;

  iib_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .frequency_limit
  );

  iib_core u_core (
    .clk, .rst, .start, .cmd, .token_id, .end_of_record, .entry_position,
    .frequency_limit, .busy, .done, .result
  );

  assign status          = result.status;
  assign record_number   = result.record_number;
  assign list_length     = result.list_length;
  assign total_entries   = result.total_entries;
  assign distinct_tokens = result.distinct_tokens;

endmodule

FILE: rtl/iib_checker.sv
// ----------------------------------------------------------------------------
// iib_checker: port-level checks of the inverted index builder
// Watches the command handshake and the result strobe.
// ----------------------------------------------------------------------------
module iib_checker
  import iib_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [2:0] status,
  input logic       pready
);

  // done is asserted again without a gap only for a new transaction
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done && $past(done) |-> $past(start && !busy))
    else $error("done held without new transaction");

  // Status codes stay in range
  a_status: assert property (@(posedge clk) disable iff (rst)
    done |-> status <= ST_OVERFLOW)
    else $error("bad status");

  // pready is always high
  a_ready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind inverted_index_builder_top iib_checker u_chk (
  .clk, .rst, .start, .busy, .done, .status, .pready
);
